// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion, checked at every edge.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants and types of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int SLOT_COUNT_DEF = 1024;
    localparam int MAP_WORD_W     = 64;
    localparam int BIT_IW         = 6;
    localparam int IDX_W          = 10;
    localparam int GRANT_W        = 10;
    localparam int USED_W         = 11;
    localparam int STATUS_W       = 2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_USED = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } state_t;

endpackage

// ----- design/bitmap_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// First-free slot allocator over a used/free bitmap held in a word RAM.
// ----------------------------------------------------------------------------
//  channel | ports                                         | dir
//  s_      | s_valid s_ready s_func s_slot_index           | request beat in
//  m_      | m_valid m_ready m_status m_granted_slot       | result beat out
//          | m_now_full m_now_empty m_used_slots           |
//
//  Each request first reads the map word (a per-word full flag picks it
//  on an allocation, the slot index on a free), then updates it and
//  writes it back. A stalled result holds the block in its update cycle.
//  Reset clears per-word valid and full flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
    parameter int SLOT_COUNT = bsa_pkg::SLOT_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [bsa_pkg::IDX_W-1:0]     s_slot_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bsa_pkg::STATUS_W-1:0]  m_status,
    output logic [bsa_pkg::GRANT_W-1:0]   m_granted_slot,
    output logic                          m_now_full,
    output logic                          m_now_empty,
    output logic [bsa_pkg::USED_W-1:0]    m_used_slots
);

    localparam int WB       = bsa_pkg::MAP_WORD_W;
    localparam int WORDS    = (SLOT_COUNT + WB - 1) / WB;
    localparam int WORD_IW  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int LAST_REM = SLOT_COUNT % WB;
    localparam int SLOT_IW  = WORD_IW + bsa_pkg::BIT_IW;
    localparam logic [WB-1:0] TAIL_MASK =
        (LAST_REM == 0) ? {WB{1'b1}} : ((WB'(1) << LAST_REM) - WB'(1));

    bsa_pkg::state_t  state_reg, state_next;
    bsa_pkg::status_t status_res;

    logic                          func_reg;
    logic [bsa_pkg::IDX_W-1:0]     idx_reg;
    logic [WORD_IW-1:0]            addr_reg;
    logic                          any_free_reg;
    logic                          range_ok_reg;
    logic [WORDS-1:0]              valid_reg;
    logic [WORDS-1:0]              full_reg;
    logic [CNT_W-1:0]              used_reg, used_next;

    logic                          m_valid_reg;
    logic [bsa_pkg::STATUS_W-1:0]  status_reg;
    logic [bsa_pkg::GRANT_W-1:0]   granted_reg;
    logic                          now_full_reg;
    logic                          now_empty_reg;
    logic [bsa_pkg::USED_W-1:0]    used_out_reg;

    logic                          s_acc;
    logic                          rd_en;
    logic                          in_range;
    logic [31:0]                   idx_ext;
    logic [WORD_IW-1:0]            rd_addr;
    logic                          word_found;
    logic [WORD_IW-1:0]            word_idx;
    logic [WB-1:0]                 rd_data;
    logic [WB-1:0]                 cur_word;
    logic [WB-1:0]                 word_mask;
    logic [WB-1:0]                 free_bits;
    logic [WB-1:0]                 new_word;
    logic                          bit_found;
    logic [bsa_pkg::BIT_IW-1:0]    bit_idx;
    logic [bsa_pkg::BIT_IW-1:0]    rel_bit;
    logic                          wr_req;
    logic                          wr_en;
    logic                          finish;
    logic [SLOT_IW-1:0]            granted_wide;
    logic [SLOT_IW+bsa_pkg::GRANT_W-1:0] granted_ext;
    logic [CNT_W+bsa_pkg::USED_W-1:0]    used_ext;

    // request side
    assign s_acc    = s_valid && s_ready;
    assign idx_ext  = 32'(s_slot_index);
    assign in_range = idx_ext < 32'(SLOT_COUNT);

    bsa_lowest #(.N(WORDS)) u_word_find (
        .vec   (~full_reg),
        .found (word_found),
        .idx   (word_idx)
    );

    always_comb begin
        if (s_func == bsa_pkg::FUNC_ALLOC) begin
            rd_addr = word_idx;
        end else if (in_range) begin
            rd_addr = idx_ext[bsa_pkg::BIT_IW +: WORD_IW];
        end else begin
            rd_addr = '0;
        end
    end

    bsa_ram #(.WIDTH(WB), .DEPTH(WORDS)) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (new_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // update side
    assign cur_word  = valid_reg[addr_reg] ? rd_data : '0;
    assign word_mask = (32'(addr_reg) == 32'(WORDS - 1)) ? TAIL_MASK : {WB{1'b1}};
    assign free_bits = ~cur_word & word_mask;
    assign rel_bit   = idx_reg[bsa_pkg::BIT_IW-1:0];

    bsa_lowest #(.N(WB)) u_bit_find (
        .vec   (free_bits),
        .found (bit_found),
        .idx   (bit_idx)
    );

    always_comb begin
        new_word     = cur_word;
        wr_req       = 1'b0;
        status_res   = bsa_pkg::ST_OK;
        granted_wide = '0;
        used_next    = used_reg;
        if (func_reg == bsa_pkg::FUNC_ALLOC) begin
            if (any_free_reg && bit_found) begin
                new_word     = cur_word | (WB'(1) << bit_idx);
                wr_req       = 1'b1;
                granted_wide = {addr_reg, bit_idx};
                used_next    = used_reg + CNT_W'(1);
            end else begin
                status_res = bsa_pkg::ST_FULL;
            end
        end else if (!range_ok_reg) begin
            status_res = bsa_pkg::ST_RANGE;
        end else if (!cur_word[rel_bit]) begin
            status_res = bsa_pkg::ST_NOT_USED;
        end else begin
            new_word = cur_word & ~(WB'(1) << rel_bit);
            wr_req   = 1'b1;
            if (used_reg != '0) begin
                used_next = used_reg - CNT_W'(1);
            end
        end
    end

    assign finish      = (state_reg == bsa_pkg::S_BUSY) && (!m_valid_reg || m_ready);
    assign wr_en       = finish && wr_req;
    assign granted_ext = {{bsa_pkg::GRANT_W{1'b0}}, granted_wide};
    assign used_ext    = {{bsa_pkg::USED_W{1'b0}}, used_next};

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bsa_pkg::S_IDLE: begin
                if (s_acc) begin
                    state_next = bsa_pkg::S_BUSY;
                end
            end
            bsa_pkg::S_BUSY: begin
                if (finish) begin
                    state_next = bsa_pkg::S_IDLE;
                end
            end
            default: state_next = bsa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == bsa_pkg::S_IDLE);
        rd_en   = s_valid && (state_reg == bsa_pkg::S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bsa_pkg::S_IDLE;
            valid_reg   <= '0;
            full_reg    <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                valid_reg[addr_reg] <= 1'b1;
                full_reg[addr_reg]  <= &(new_word | ~word_mask);
            end
            if (finish) begin
                used_reg    <= used_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            func_reg     <= s_func;
            idx_reg      <= s_slot_index;
            addr_reg     <= rd_addr;
            any_free_reg <= word_found;
            range_ok_reg <= in_range;
        end
        if (finish) begin
            status_reg    <= status_res;
            granted_reg   <= granted_ext[bsa_pkg::GRANT_W-1:0];
            now_full_reg  <= (32'(used_next) == 32'(SLOT_COUNT));
            now_empty_reg <= (used_next == '0);
            used_out_reg  <= used_ext[bsa_pkg::USED_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_granted_slot = granted_reg;
    assign m_now_full     = now_full_reg;
    assign m_now_empty    = now_empty_reg;
    assign m_used_slots   = used_out_reg;

endmodule

// ----- design/bsa_ram.sv -----
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/bsa_lowest.sv -----
// ----------------------------------------------------------------------------
// bsa_lowest
// Priority encoder: index of the lowest set bit of a vector.
// ----------------------------------------------------------------------------
module bsa_lowest #(
    parameter int N = 64
) (
    input  logic [N-1:0]                       vec,
    output logic                               found,
    output logic [((N > 1) ? $clog2(N) : 1)-1:0] idx
);

    localparam int IW = (N > 1) ? $clog2(N) : 1;

    always_comb begin
        found = |vec;
        idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IW'(i);
            end
        end
    end

endmodule

// ----- design/bsa_checker.sv -----
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks on the bitmap slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsa_checker #(
    parameter int SLOT_COUNT = bsa_pkg::SLOT_COUNT_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_func,
    input logic [bsa_pkg::IDX_W-1:0]     s_slot_index,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bsa_pkg::STATUS_W-1:0]  m_status,
    input logic [bsa_pkg::GRANT_W-1:0]   m_granted_slot,
    input logic                          m_now_full,
    input logic                          m_now_empty,
    input logic [bsa_pkg::USED_W-1:0]    m_used_slots
);

    // result beat holds while stalled
    `ASSERT_RST(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_used_slots), "result beat changed while stalled")

    // one request in flight at a time
    `ASSERT_RST(a_one_req, aclk, aresetn, s_valid && s_ready |=> !s_ready, "request taken while busy")

    // full and empty never together
    `ASSERT_RST(a_flags, aclk, aresetn, m_valid |-> !(m_now_full && m_now_empty), "full and empty both set")

    // empty flag agrees with the count
    `ASSERT_RST(a_empty, aclk, aresetn, m_valid && (SLOT_COUNT < 2048) |-> (m_now_empty == (m_used_slots == '0)), "empty flag disagrees with count")

    // a full report grants nothing and shows a full map
    `ASSERT_RST(a_full, aclk, aresetn, m_valid && (m_status == bsa_pkg::ST_FULL) |-> m_now_full && (m_granted_slot == '0), "bad full report")

endmodule

bind bitmap_slot_allocator bsa_checker #(.SLOT_COUNT(SLOT_COUNT)) u_bsa_checker (.*);
